### src/tcce_pkg.sv
// Shared types, constants and codes for the text console cursor engine.
// No dependencies; every other file imports this package.
package tcce_pkg;

  // Screen geometry
  localparam int ROWS     = 25;
  localparam int COLUMNS  = 80;
  localparam int TAB_STOP = 8;
  localparam int NCELLS   = ROWS * COLUMNS;

  // Field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int IDX_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;
  localparam int FUNC_W = 2;

  // Operation codes carried on the input item
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  // Register addresses
  localparam logic [0:0] REG_TEXT_ATTRIBUTE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_SCROLL,
    ST_BLANK,
    ST_CLEAR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [IDX_W-1:0]  loc;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } result_t;

endpackage

### src/tcce_screen_ram.sv
// Screen cell memory: one write port, one read port with registered data.
// Depends on tcce_pkg for depth and widths.
module tcce_screen_ram
  import tcce_pkg::*;
(
  input  logic              clk,
  input  ram_req_t          req,
  output logic [CELL_W-1:0] rd_data
);

  logic [CELL_W-1:0] mem [NCELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

### src/tcce_ctrl.sv
// Cursor sequencer: decodes items, updates the cursor and drives the
// screen memory through scroll and clear sweeps. Depends on tcce_pkg.
module tcce_ctrl
  import tcce_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] func,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [IDX_W-1:0]  cell_index,
  input  logic [ATTR_W-1:0] attr,
  input  logic              res_ready,
  output logic              res_valid,
  output result_t           res,
  output ram_req_t          ram_req,
  input  logic [CELL_W-1:0] rd_data
);

  state_t            state;
  state_t            state_next;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [IDX_W-1:0]  cnt;
  logic [CELL_W-1:0] read_data;

  logic [COL_W:0]    put_col;
  logic [ROW_W:0]    put_row;
  logic [COL_W-1:0]  put_col_next;
  logic [ROW_W-1:0]  put_row_next;
  logic              put_scroll;
  logic              put_we;
  logic [IDX_W-1:0]  cur_addr;
  logic              read_ok;
  logic [CELL_W-1:0] blank;

  localparam logic [IDX_W-1:0] SHIFT_LAST = IDX_W'(NCELLS - COLUMNS);
  localparam logic [IDX_W-1:0] CELL_LAST  = IDX_W'(NCELLS - 1);

  // Smallest tab stop above the column
  function automatic logic [COL_W:0] tab_next(input logic [COL_W-1:0] c);
    logic [COL_W:0] r;
    r = '0;
    for (int k = COLUMNS / TAB_STOP + 1; k >= 1; k--) begin
      if ((k * TAB_STOP) > int'(c)) r = (COL_W+1)'(k * TAB_STOP);
    end
    return r;
  endfunction

  assign blank    = {attr, CH_SPACE};
  assign cur_addr = IDX_W'(row) * IDX_W'(COLUMNS) + IDX_W'(col);
  assign read_ok  = (cell_index < IDX_W'(NCELLS));
  assign put_we   = (char_code[7] == 1'b0) && (char_code >= CH_SPACE);

  // Cursor movement for a put item
  always_comb begin
    put_col      = {1'b0, col};
    put_row      = {1'b0, row};
    put_scroll   = 1'b0;
    put_col_next = col;
    put_row_next = row;
    case (char_code)
      CH_BS: begin
        if (col != '0) put_col = {1'b0, col} - 1'b1;
      end
      CH_TAB: put_col = tab_next(col);
      CH_CR:  put_col = '0;
      CH_LF: begin
        put_col = '0;
        put_row = {1'b0, row} + 1'b1;
      end
      default: begin
        if (put_we) put_col = {1'b0, col} + 1'b1;
      end
    endcase
    if (put_col >= (COL_W+1)'(COLUMNS)) begin
      put_col = '0;
      put_row = put_row + 1'b1;
    end
    if (put_row >= (ROW_W+1)'(ROWS)) begin
      put_scroll = 1'b1;
      put_row    = (ROW_W+1)'(ROWS - 1);
    end
    put_col_next = put_col[COL_W-1:0];
    put_row_next = put_row[ROW_W-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (func)
            FUNC_PUT:   state_next = put_scroll ? ST_SCROLL : ST_FINISH;
            FUNC_CLEAR: state_next = ST_CLEAR;
            FUNC_READ:  state_next = read_ok ? ST_RDWAIT : ST_FINISH;
            default:    state_next = ST_FINISH;
          endcase
        end
      end
      ST_RDWAIT: state_next = ST_FINISH;
      ST_SCROLL: begin
        if (cnt == SHIFT_LAST) state_next = ST_BLANK;
      end
      ST_BLANK, ST_CLEAR: begin
        if (cnt == CELL_LAST) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    ram_req       = '0;
    res.col       = col;
    res.row       = row;
    res.loc       = cur_addr;
    res.cell_data = read_data;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && func == FUNC_PUT && put_we) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = cur_addr;
          ram_req.wdata = {attr, char_code};
        end
        if (in_valid && func == FUNC_READ && read_ok) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = cell_index;
        end
      end
      ST_SCROLL: begin
        // read one row ahead, write back what the previous cycle fetched
        ram_req.re    = (cnt != SHIFT_LAST);
        ram_req.raddr = cnt + IDX_W'(COLUMNS);
        ram_req.we    = (cnt != '0);
        ram_req.waddr = cnt - 1'b1;
        ram_req.wdata = rd_data;
      end
      ST_BLANK, ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt;
        ram_req.wdata = blank;
      end
      ST_FINISH: res_valid = res_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      col   <= '0;
      row   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_valid) begin
        if (func == FUNC_PUT) begin
          col <= put_col_next;
          row <= put_row_next;
        end else if (func == FUNC_CLEAR) begin
          col <= '0;
          row <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cnt       <= '0;
        read_data <= '0;
      end
      ST_RDWAIT: read_data <= rd_data;
      ST_SCROLL: begin
        if (cnt != SHIFT_LAST) cnt <= cnt + 1'b1;
      end
      ST_BLANK, ST_CLEAR: cnt <= cnt + 1'b1;
      default: ;
    endcase
  end

endmodule

### src/text_console_cursor_engine.sv
// Text console cursor engine top level: register port, result register,
// sequencer and screen memory. Depends on tcce_pkg, tcce_ctrl, tcce_screen_ram.
//
// Usage:
//  - Input items arrive on s_tvalid/s_tready with s_tuser carrying the
//    operation (put character, clear screen, read cell) and s_tdata the
//    character byte and cell index. Each item gives exactly one result item
//    on m_tvalid/m_tready: cursor column, row, linear location and, for a
//    read, the cell contents.
//  - Item flow: a put goes straight to its result, a read first waits for
//    the registered memory data, a put that scrolls first moves the rows up
//    and blanks the last row (one cell a cycle through the single write
//    port) and a clear blanks every cell. One item is in work at a time;
//    the next is taken once the result has moved to the output register.
//  - Reset clears the cursor to home and sets the attribute to 0x0F. The
//    screen memory is not cleared: issue a clear item before reading cells.
//  - When the receiver stalls, the result waits in the output register; the
//    block still accepts one more item and holds its result until the
//    register empties.
//  - text_attribute sits at byte address 0 of the register port and should
//    be written only while the block is idle.
module text_console_cursor_engine
  import tcce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // char_code[7:0], cell_index[18:8], zero fill
  input  logic [1:0]  s_tuser,  // func[1:0]
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // cursor_col[6:0], cursor_row[11:7],
                                // cursor_location[22:12], read_cell[38:23],
                                // zero fill
);

  logic [ATTR_W-1:0] text_attribute;
  logic              res_ready;
  logic              res_valid;
  result_t           res;
  ram_req_t          ram_req;
  logic [CELL_W-1:0] rd_data;

  // register port: always ready, write in the access phase
  assign pready = 1'b1;
  assign prdata = (paddr == REG_TEXT_ATTRIBUTE) ? {24'd0, text_attribute} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_TEXT_ATTRIBUTE) begin
      text_attribute <= pwdata[ATTR_W-1:0];
    end
  end

  // result register: load when empty or being drained this cycle
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= {1'b0, res.cell_data, res.loc, res.row, res.col};
    end
  end

  tcce_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .func       (s_tuser),
    .char_code  (s_tdata[7:0]),
    .cell_index (s_tdata[18:8]),
    .attr       (text_attribute),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res),
    .ram_req    (ram_req),
    .rd_data    (rd_data)
  );

  tcce_screen_ram u_screen (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

endmodule
